@@ sv/sorted_name_table_defines.svh @@
// Assertion macros for the sorted name table.
// Used by sorted_name_table.sv; expects clk and rst in scope.
`ifndef SORTED_NAME_TABLE_DEFINES_SVH
`define SORTED_NAME_TABLE_DEFINES_SVH

// same-cycle implication
`define SNT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_name_table: assertion failed");

// next-cycle implication
`define SNT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_name_table: assertion failed");

`endif

@@ sv/snt_pkg.sv @@
// Package for the sorted name table: sizes, codes and transfer types.
// No dependencies.
`default_nettype none

package snt_pkg;

  localparam int DEPTH      = 32;
  localparam int NAME_BYTES = 8;
  localparam int NAME_W     = 64;
  localparam int PHONE_W    = 50;
  localparam int COUNT_W    = 16;
  localparam int TOTAL_W    = 6;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam logic [NAME_W-1:0] KEY_MASK = {NAME_W{1'b1}} << (NAME_W - 8 * NAME_BYTES);

  localparam logic [OP_W-1:0] OP_INSERT     = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE     = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND_NAME  = 2'd2;
  localparam logic [OP_W-1:0] OP_FIND_PHONE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [NAME_W-1:0]  name_key;
    logic [PHONE_W-1:0] phone;
    logic [COUNT_W-1:0] in_calls;
    logic [COUNT_W-1:0] out_calls;
  } snt_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PHONE_W-1:0]  phone_out;
    logic [COUNT_W-1:0]  in_calls_out;
    logic [COUNT_W-1:0]  out_calls_out;
    logic [TOTAL_W-1:0]  entry_total;
  } snt_res_t;

  typedef struct packed {
    logic [NAME_W-1:0]  name;
    logic [PHONE_W-1:0] phone;
    logic [COUNT_W-1:0] in_cnt;
    logic [COUNT_W-1:0] out_cnt;
  } snt_entry_t;

  localparam int ENTRY_W = $bits(snt_entry_t);

  typedef struct packed {
    logic                fin;
    logic [STATUS_W-1:0] status;
    logic [PHONE_W-1:0]  phone_out;
    logic [COUNT_W-1:0]  in_calls_out;
    logic [COUNT_W-1:0]  out_calls_out;
    logic [TOTAL_W-1:0]  entry_total;
  } snt_status_t;

endpackage

`default_nettype wire

@@ sv/snt_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module snt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/snt_seq.sv @@
// Sequencer for the sorted name table: binary search, entry shift and phone
// scan over the entry RAM, all through one name/phone compare unit.
// Depends on snt_pkg.
`default_nettype none

module snt_seq (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire snt_pkg::snt_cmd_t            cmd,
  output logic                              busy,
  output logic                              we,
  output logic [snt_pkg::ADDR_W-1:0]        waddr,
  output logic [snt_pkg::ENTRY_W-1:0]       wdata,
  output logic [snt_pkg::ADDR_W-1:0]        raddr,
  input  wire logic [snt_pkg::ENTRY_W-1:0]  rdata,
  output snt_pkg::snt_status_t              stat
);

  import snt_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_BS_ISSUE = 3'd1;
  localparam logic [2:0] S_BS_CMP   = 3'd2;
  localparam logic [2:0] S_LK_CMP   = 3'd3;
  localparam logic [2:0] S_SHIFT    = 3'd4;
  localparam logic [2:0] S_PUT      = 3'd5;
  localparam logic [2:0] S_SCAN     = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]          state, state_next;
  logic [OP_W-1:0]     op, op_next;
  logic [NAME_W-1:0]   key, key_next;
  logic [PHONE_W-1:0]  ph, ph_next;
  logic [COUNT_W-1:0]  inc, inc_next;
  logic [COUNT_W-1:0]  outc, outc_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    lo, lo_next;
  logic [CNT_W-1:0]    hi, hi_next;
  logic [CNT_W-1:0]    mid, mid_next;
  logic [CNT_W-1:0]    src, src_next;
  logic [CNT_W-1:0]    moves, moves_next;
  logic                pend, pend_next;
  logic [CNT_W-1:0]    pend_dst, pend_dst_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [PHONE_W-1:0]  res_phone, res_phone_next;
  logic [COUNT_W-1:0]  res_inc, res_inc_next;
  logic [COUNT_W-1:0]  res_outc, res_outc_next;

  snt_entry_t          rd_entry;
  snt_entry_t          new_entry;
  logic [CNT_W-1:0]    mid_calc;
  logic                name_lt, name_eq, phone_eq, go_right;

  assign rd_entry  = snt_entry_t'(rdata);
  assign new_entry = '{name: key, phone: ph, in_cnt: inc, out_cnt: outc};
  assign mid_calc  = lo + ((hi - lo) >> 1);

  // shared compare unit
  assign name_lt  = rd_entry.name < key;
  assign name_eq  = rd_entry.name == key;
  assign phone_eq = rd_entry.phone == ph;
  assign go_right = (op == OP_INSERT) ? (name_lt || name_eq) : name_lt;

  always_comb begin
    state_next      = state;
    op_next         = op;
    key_next        = key;
    ph_next         = ph;
    inc_next        = inc;
    outc_next       = outc;
    count_next      = count;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    src_next        = src;
    moves_next      = moves;
    pend_next       = pend;
    pend_dst_next   = pend_dst;
    res_status_next = res_status;
    res_phone_next  = res_phone;
    res_inc_next    = res_inc;
    res_outc_next   = res_outc;
    we              = 1'b0;
    waddr           = pend_dst[ADDR_W-1:0];
    wdata           = rdata;
    raddr           = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next         = cmd.opcode;
          key_next        = cmd.name_key & KEY_MASK;
          ph_next         = cmd.phone;
          inc_next        = cmd.in_calls;
          outc_next       = cmd.out_calls;
          lo_next         = '0;
          hi_next         = count;
          src_next        = '0;
          pend_next       = 1'b0;
          res_status_next = ST_NOT_FOUND;
          res_phone_next  = '0;
          res_inc_next    = '0;
          res_outc_next   = '0;
          if (cmd.opcode == OP_INSERT && count == CNT_W'(DEPTH)) begin
            res_status_next = ST_FULL;
            state_next      = S_DONE;
          end else if (cmd.opcode == OP_FIND_PHONE) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_BS_ISSUE;
          end
        end
      end
      S_BS_ISSUE: begin
        if (lo < hi) begin
          raddr      = mid_calc[ADDR_W-1:0];
          mid_next   = mid_calc;
          state_next = S_BS_CMP;
        end else if (op == OP_INSERT) begin
          moves_next = count - lo;
          src_next   = count - CNT_W'(1);
          pend_next  = 1'b0;
          state_next = S_SHIFT;
        end else if (lo < count) begin
          raddr      = lo[ADDR_W-1:0];
          state_next = S_LK_CMP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_BS_CMP: begin
        if (go_right) begin
          lo_next = mid + CNT_W'(1);
        end else begin
          hi_next = mid;
        end
        state_next = S_BS_ISSUE;
      end
      S_LK_CMP: begin
        if (name_eq) begin
          res_status_next = ST_OK;
          if (op == OP_FIND_NAME) begin
            res_phone_next = rd_entry.phone;
            state_next     = S_DONE;
          end else begin
            moves_next = count - lo - CNT_W'(1);
            src_next   = lo + CNT_W'(1);
            pend_next  = 1'b0;
            state_next = S_SHIFT;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        // read one entry ahead, write the previous read to its new slot
        if (pend) begin
          we = 1'b1;
        end
        if (moves != '0) begin
          raddr      = src[ADDR_W-1:0];
          pend_next  = 1'b1;
          moves_next = moves - CNT_W'(1);
          if (op == OP_INSERT) begin
            pend_dst_next = src + CNT_W'(1);
            src_next      = src - CNT_W'(1);
          end else begin
            pend_dst_next = src - CNT_W'(1);
            src_next      = src + CNT_W'(1);
          end
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            if (op == OP_INSERT) begin
              state_next = S_PUT;
            end else begin
              count_next      = count - CNT_W'(1);
              res_status_next = ST_OK;
              state_next      = S_DONE;
            end
          end
        end
      end
      S_PUT: begin
        we              = 1'b1;
        waddr           = lo[ADDR_W-1:0];
        wdata           = new_entry;
        count_next      = count + CNT_W'(1);
        res_status_next = ST_OK;
        state_next      = S_DONE;
      end
      S_SCAN: begin
        if (pend && phone_eq) begin
          res_status_next = ST_OK;
          res_inc_next    = rd_entry.in_cnt;
          res_outc_next   = rd_entry.out_cnt;
          state_next      = S_DONE;
        end else if (src < count) begin
          raddr     = src[ADDR_W-1:0];
          src_next  = src + CNT_W'(1);
          pend_next = 1'b1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
    op         <= op_next;
    key        <= key_next;
    ph         <= ph_next;
    inc        <= inc_next;
    outc       <= outc_next;
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    src        <= src_next;
    moves      <= moves_next;
    pend_dst   <= pend_dst_next;
    res_status <= res_status_next;
    res_phone  <= res_phone_next;
    res_inc    <= res_inc_next;
    res_outc   <= res_outc_next;
  end

  assign busy               = (state != S_IDLE);
  assign stat.fin           = (state == S_DONE);
  assign stat.status        = res_status;
  assign stat.phone_out     = res_phone;
  assign stat.in_calls_out  = res_inc;
  assign stat.out_calls_out = res_outc;
  assign stat.entry_total   = TOTAL_W'(count);

endmodule

`default_nettype wire

@@ sv/sorted_name_table.sv @@
// Top level of the sorted name table: sequencer, entry RAM, result register.
// Depends on snt_pkg, snt_seq, snt_ram, sorted_name_table_defines.svh.
//
//   channel  ports               qualifier
//   command  cmd (snt_cmd_t)     start && !busy
//   result   res (snt_res_t)     done, one cycle, no back-pressure
//
// Each binary search probe reads the RAM, then compares the name; a closing check
// ends the search. Insert and delete then shift the entries behind the slot, with
// each read one entry ahead of its write; insert then puts the new entry in.
// Phone lookup scans one entry per cycle.
// Synchronous reset empties the table at once; RAM contents are not cleared.
`default_nettype none
`include "sorted_name_table_defines.svh"

module sorted_name_table (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire snt_pkg::snt_cmd_t  cmd,
  output logic                    busy,
  output logic                    done,
  output snt_pkg::snt_res_t       res
);

  import snt_pkg::*;

  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [ENTRY_W-1:0]  wdata;
  logic [ADDR_W-1:0]   raddr;
  logic [ENTRY_W-1:0]  rdata;
  snt_status_t         stat;
  logic                accept;

  assign accept = start && !busy;

  snt_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .cmd   (cmd),
    .busy  (busy),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata),
    .stat  (stat)
  );

  snt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stat.fin;
    end
    if (stat.fin) begin
      res.status        <= stat.status;
      res.phone_out     <= stat.phone_out;
      res.in_calls_out  <= stat.in_calls_out;
      res.out_calls_out <= stat.out_calls_out;
      res.entry_total   <= stat.entry_total;
    end
  end

  `SNT_ASSERT_NXT(a_accept_busy, accept, busy)
  `SNT_ASSERT_IMP(a_done_after_busy, done, $past(busy))
  `SNT_ASSERT_IMP(a_total_bound, done, res.entry_total <= TOTAL_W'(DEPTH))
  `SNT_ASSERT_IMP(a_full_total, done && res.status == ST_FULL, res.entry_total == TOTAL_W'(DEPTH))

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Testbench for sorted_name_table: directed table, then random insert/delete/lookup runs.
// Uses snt_pkg types; results are checked against a shadow copy of the sorted table or a typed expectation.
module tb;
  import snt_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int RAND_ITEMS   = 800;
  localparam int DRAIN_CYCLES = 64;
  localparam logic [NAME_W-1:0]  NAME_ONES = {NAME_W{1'b1}};
  localparam logic [NAME_W-1:0]  NAME_ALICE = 64'h414C_4943_4500_0000;
  localparam logic [NAME_W-1:0]  NAME_AL = 64'h414C_0000_0000_0000;
  localparam logic [NAME_W-1:0]  NAME_BOB = 64'h424F_4200_0000_0000;
  localparam logic [PHONE_W-1:0] PH_MAX = 50'd999999999999999;

  typedef enum int {FILL_UP, DRAIN_DOWN, MIXED} mix_t;

  typedef struct {
    snt_cmd_t c;
    bit       typed;
    snt_res_t r;
  } dir_row_t;

  logic     clk;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  snt_cmd_t cmd = '0;
  logic     busy;
  logic     done;
  snt_res_t res;

  // expectation typed in the directed table travels alongside the command
  logic     row_typed = 1'b0;
  snt_res_t row_res = '0;

  snt_entry_t shadow_table [DEPTH];
  int         shadow_count = 0;
  snt_res_t   awaited_results [$];
  logic [NAME_W-1:0]  name_pool [16];
  logic [PHONE_W-1:0] phone_pool [16];

  int errors = 0;
  int cycles = 0;
  int n_checked = 0;
  int n_full = 0;
  int n_hits = 0;
  int n_misses = 0;
  int peak_count = 0;

  sorted_name_table i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done),
    .res   (res)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("%0t timeout after %0d cycles, %0d results outstanding", $time, cycles,
               awaited_results.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  // shadow of the table: applies one command, returns the result it must produce
  function automatic snt_res_t apply_to_shadow_table(snt_cmd_t c);
    snt_res_t          r;
    logic [NAME_W-1:0] key;
    int                pos;
    r = '0;
    r.status = ST_NOT_FOUND;
    key = c.name_key & KEY_MASK;
    pos = 0;
    case (c.opcode)
      OP_INSERT: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          while (pos < shadow_count && shadow_table[pos].name <= key) pos++;
          for (int i = shadow_count; i > pos; i--) shadow_table[i] = shadow_table[i-1];
          shadow_table[pos] = '{key, c.phone, c.in_calls, c.out_calls};
          shadow_count++;
          r.status = ST_OK;
        end
      end
      OP_DELETE, OP_FIND_NAME: begin
        while (pos < shadow_count && shadow_table[pos].name < key) pos++;
        if (pos < shadow_count && shadow_table[pos].name == key) begin
          r.status = ST_OK;
          if (c.opcode == OP_FIND_NAME) begin
            r.phone_out = shadow_table[pos].phone;
          end else begin
            for (int i = pos; i + 1 < shadow_count; i++) shadow_table[i] = shadow_table[i+1];
            shadow_count--;
          end
        end
      end
      OP_FIND_PHONE: begin
        while (pos < shadow_count && shadow_table[pos].phone != c.phone) pos++;
        if (pos < shadow_count) begin
          r.status = ST_OK;
          r.in_calls_out = shadow_table[pos].in_cnt;
          r.out_calls_out = shadow_table[pos].out_cnt;
        end
      end
    endcase
    r.entry_total = TOTAL_W'(shadow_count);
    return r;
  endfunction

  task automatic report_field(string field, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t mismatch %s: expected %0h, got %0h", $time, field, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    snt_res_t predicted;
    snt_res_t exp_r;
    if (!rst && start && !busy) begin
      predicted = apply_to_shadow_table(cmd);
      awaited_results.push_back(row_typed ? row_res : predicted);
      if (shadow_count > peak_count) peak_count = shadow_count;
    end
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        $display("%0t unexpected result: expected none, got %0h", $time, res);
        errors++;
      end else begin
        exp_r = awaited_results.pop_front();
        report_field("status", 64'(exp_r.status), 64'(res.status));
        report_field("phone_out", 64'(exp_r.phone_out), 64'(res.phone_out));
        report_field("in_calls_out", 64'(exp_r.in_calls_out), 64'(res.in_calls_out));
        report_field("out_calls_out", 64'(exp_r.out_calls_out), 64'(res.out_calls_out));
        report_field("entry_total", 64'(exp_r.entry_total), 64'(res.entry_total));
        n_checked++;
        if (exp_r.status == ST_FULL) n_full++;
        else if (exp_r.status == ST_OK) n_hits++;
        else n_misses++;
      end
    end
  end

  function automatic snt_cmd_t cmd_of(logic [OP_W-1:0] op, logic [NAME_W-1:0] nm,
                                      logic [PHONE_W-1:0] ph, logic [COUNT_W-1:0] ic,
                                      logic [COUNT_W-1:0] oc);
    return '{op, nm, ph, ic, oc};
  endfunction

  function automatic snt_res_t res_of(logic [STATUS_W-1:0] st, logic [PHONE_W-1:0] ph,
                                      logic [COUNT_W-1:0] ic, logic [COUNT_W-1:0] oc,
                                      int total);
    return '{st, ph, ic, oc, TOTAL_W'(total)};
  endfunction

  function automatic logic [PHONE_W-1:0] any_phone();
    logic [63:0] t;
    t = {$urandom, $urandom};
    return PHONE_W'(t % 64'd1000000000000000);
  endfunction

  function automatic logic [OP_W-1:0] pick_op(mix_t m);
    int roll;
    roll = $urandom_range(0, 99);
    case (m)
      FILL_UP: begin
        if (roll < 75) return OP_INSERT;
        if (roll < 84) return OP_DELETE;
        if (roll < 92) return OP_FIND_NAME;
        return OP_FIND_PHONE;
      end
      DRAIN_DOWN: begin
        if (roll < 10) return OP_INSERT;
        if (roll < 70) return OP_DELETE;
        if (roll < 85) return OP_FIND_NAME;
        return OP_FIND_PHONE;
      end
      default: return OP_W'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic snt_cmd_t random_cmd(mix_t m);
    snt_cmd_t c;
    c.opcode = pick_op(m);
    c.name_key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                              : name_pool[$urandom_range(0, 15)];
    c.phone = ($urandom_range(0, 4) == 0) ? any_phone() : phone_pool[$urandom_range(0, 15)];
    c.in_calls = COUNT_W'($urandom);
    c.out_calls = COUNT_W'($urandom);
    return c;
  endfunction

  task automatic send_cmd(snt_cmd_t c, bit typed, snt_res_t r, bit may_idle);
    if (may_idle && $urandom_range(0, 99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    row_typed <= typed;
    row_res <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin : stimulus
    dir_row_t directed_rows [$];
    logic [NAME_W-1:0] nm;
    mix_t mode;
    int   sent;
    int   run_len;
    bit   first_run;

    directed_rows = '{
      '{cmd_of(OP_DELETE, NAME_ALICE, 50'd0, 16'd7, 16'd9), 1'b1,
        res_of(ST_NOT_FOUND, 50'd0, 16'd0, 16'd0, 0)},
      '{cmd_of(OP_FIND_NAME, NAME_ALICE, 50'd5, 16'd0, 16'd0), 1'b1,
        res_of(ST_NOT_FOUND, 50'd0, 16'd0, 16'd0, 0)},
      '{cmd_of(OP_FIND_PHONE, NAME_ONES, 50'd0, 16'd0, 16'd0), 1'b1,
        res_of(ST_NOT_FOUND, 50'd0, 16'd0, 16'd0, 0)},
      '{cmd_of(OP_INSERT, NAME_ONES, PH_MAX, 16'hFFFF, 16'hFFFF), 1'b1,
        res_of(ST_OK, 50'd0, 16'd0, 16'd0, 1)},
      '{cmd_of(OP_INSERT, '0, 50'd0, 16'd0, 16'd0), 1'b1,
        res_of(ST_OK, 50'd0, 16'd0, 16'd0, 2)},
      '{cmd_of(OP_FIND_NAME, NAME_ONES, 50'd0, 16'd0, 16'd0), 1'b1,
        res_of(ST_OK, PH_MAX, 16'd0, 16'd0, 2)},
      '{cmd_of(OP_FIND_PHONE, '0, PH_MAX, 16'd0, 16'd0), 1'b1,
        res_of(ST_OK, 50'd0, 16'hFFFF, 16'hFFFF, 2)},
      '{cmd_of(OP_FIND_PHONE, NAME_ONES, 50'd0, 16'hFFFF, 16'hFFFF), 1'b1,
        res_of(ST_OK, 50'd0, 16'd0, 16'd0, 2)},
      '{cmd_of(OP_FIND_NAME, '0, PH_MAX, 16'd0, 16'd0), 1'b1,
        res_of(ST_OK, 50'd0, 16'd0, 16'd0, 2)},
      // equal names, shared phones and a name that is a prefix of another
      '{cmd_of(OP_INSERT, NAME_ALICE, 50'd111, 16'd1, 16'd2), 1'b0, '0},
      '{cmd_of(OP_INSERT, NAME_ALICE, 50'd222, 16'd3, 16'd4), 1'b0, '0},
      '{cmd_of(OP_INSERT, NAME_AL, 50'd111, 16'd5, 16'd6), 1'b0, '0},
      '{cmd_of(OP_INSERT, NAME_BOB, 50'd333, 16'd7, 16'd8), 1'b0, '0},
      '{cmd_of(OP_FIND_NAME, NAME_ALICE, 50'd0, 16'd0, 16'd0), 1'b0, '0},
      '{cmd_of(OP_FIND_PHONE, NAME_BOB, 50'd111, 16'd0, 16'd0), 1'b0, '0},
      '{cmd_of(OP_DELETE, NAME_ALICE, 50'd0, 16'd0, 16'd0), 1'b0, '0},
      '{cmd_of(OP_FIND_NAME, NAME_ALICE, 50'd0, 16'd0, 16'd0), 1'b0, '0},
      '{cmd_of(OP_FIND_PHONE, NAME_ALICE, 50'd222, 16'd0, 16'd0), 1'b0, '0},
      '{cmd_of(OP_DELETE, NAME_BOB, 50'd0, 16'd0, 16'd0), 1'b0, '0},
      '{cmd_of(OP_DELETE, NAME_BOB, 50'd0, 16'd0, 16'd0), 1'b0, '0},
      '{cmd_of(OP_FIND_PHONE, NAME_AL, 50'd777, 16'd0, 16'd0), 1'b0, '0},
      '{cmd_of(OP_DELETE, NAME_ONES, 50'd0, 16'd0, 16'd0), 1'b0, '0},
      '{cmd_of(OP_DELETE, '0, 50'd0, 16'd0, 16'd0), 1'b0, '0}
    };

    // names of mixed lengths, some one apart so neighbors compare closely
    name_pool[0] = '0;
    name_pool[1] = NAME_ONES;
    for (int k = 2; k < 16; k++) begin
      nm = {$urandom, $urandom};
      name_pool[k] = (k >= 10) ? name_pool[k-8] + 64'd1
                               : nm & (NAME_ONES << (8 * (8 - $urandom_range(1, 8))));
    end
    phone_pool[0] = '0;
    phone_pool[1] = PH_MAX;
    for (int k = 2; k < 16; k++) phone_pool[k] = any_phone();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k])
      send_cmd(directed_rows[k].c, directed_rows[k].typed, directed_rows[k].r, 1'b1);

    sent = 0;
    first_run = 1'b1;
    while (sent < RAND_ITEMS) begin
      mode = first_run ? FILL_UP : mix_t'($urandom_range(0, 2));
      first_run = 1'b0;
      run_len = $urandom_range(20, 60);
      repeat (run_len) begin
        send_cmd(random_cmd(mode), 1'b0, '0, !(sent >= 300 && sent < 500));
        sent++;
      end
    end
    start <= 1'b0;
    row_typed <= 1'b0;

    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d transfers: %0d hits, %0d misses, %0d inserts refused when full",
             n_checked, n_hits, n_misses, n_full);
    $display("table filled to at most %0d entries; %0d errors", peak_count, errors);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
